// ===== sv/ncot_pkg.sv =====
`default_nettype none
package ncot_pkg;

   // item kinds on the request channel
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_POINT = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;
   localparam logic [1:0] KIND_READ  = 2'd3;

   // register indexes
   localparam logic [1:0] CFG_CLUSTERS = 2'd0;
   localparam logic [1:0] CFG_DIMS     = 2'd1;
   localparam logic [1:0] CFG_OUTLIERS = 2'd2;

   // register reset values
   localparam logic [4:0] RST_CLUSTERS = 5'd16;
   localparam logic [7:0] RST_DIMS     = 8'd90;
   localparam logic [9:0] RST_OUTLIERS = 10'd500;

   // result kinds
   localparam logic RES_ASSIGN = 1'b0;
   localparam logic RES_SLOT   = 1'b1;

   localparam int COORD_W = 16;
   localparam int DIST_W  = 41;
   localparam int ID_W    = 20;
   localparam int CSR_W   = 10;
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic cent_wr;
      logic tbl_clear;
      logic acc_step;
      logic min_step;
      logic track;
      logic scan_step;
      logic slot_rd;
      logic rsp_point;
      logic rsp_read;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic coord_ok;
      logic cnt_last;
      logic acc_busy;
      logic scan_last;
      logic scan_busy;
      logic need_scan;
      logic rsp_free;
   } sts_type;

endpackage
`default_nettype wire

// ===== sv/ncot_ram.sv =====
`default_nettype none
module ncot_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== sv/ncot_datapath.sv =====
`default_nettype none
module ncot_datapath import ncot_pkg::*; #(
   parameter int MAX_CLUSTERS  = 16,
   parameter int MAX_DIMS      = 128,
   parameter int OUTLIER_SLOTS = 512
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmd_type              cmd,
   output sts_type                   sts,
   input  wire logic [3:0]           req_centroid_index,
   input  wire logic [6:0]           req_coord_index,
   input  wire logic signed [15:0]   req_coord_value,
   input  wire logic [ID_W-1:0]      req_point_id,
   input  wire logic [8:0]           req_read_slot,
   input  wire logic                 csr_valid,
   input  wire logic [1:0]           csr_index,
   input  wire logic [CSR_W-1:0]     csr_data,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output logic                      rsp_result_kind,
   output logic [3:0]                rsp_cluster,
   output logic [DIST_W-1:0]         rsp_distance,
   output logic [ID_W-1:0]           rsp_result_point,
   output logic                      rsp_kept_as_outlier,
   output logic                      rsp_slot_filled
);

   localparam int CI_W     = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int CK_W     = $clog2(MAX_CLUSTERS + 1);
   localparam int CA_DEPTH = MAX_CLUSTERS * MAX_DIMS;
   localparam int CA_W     = (CA_DEPTH > 1) ? $clog2(CA_DEPTH) : 1;
   localparam int SA_W     = (OUTLIER_SLOTS > 1) ? $clog2(OUTLIER_SLOTS) : 1;
   localparam int SC_W     = $clog2(OUTLIER_SLOTS + 1);
   localparam int TBL_W    = DIST_W + ID_W;

   // configuration registers
   logic [4:0] clusters_ff;
   logic [7:0] dims_ff;
   logic [9:0] outliers_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clusters_ff <= RST_CLUSTERS;
         dims_ff     <= RST_DIMS;
         outliers_ff <= RST_OUTLIERS;
      end else if (csr_valid) begin
         unique case (csr_index)
            CFG_CLUSTERS: clusters_ff <= csr_data[4:0];
            CFG_DIMS:     dims_ff     <= csr_data[7:0];
            CFG_OUTLIERS: outliers_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // clusters and slots in use, saturated into range
   logic [CK_W-1:0] k_lim;
   logic [SC_W-1:0] z_lim;

   always_comb begin
      if (clusters_ff == 5'd0) begin
         k_lim = CK_W'(1);
      end else if (32'(clusters_ff) > MAX_CLUSTERS) begin
         k_lim = CK_W'(MAX_CLUSTERS);
      end else begin
         k_lim = CK_W'(clusters_ff);
      end
      if (outliers_ff == 10'd0) begin
         z_lim = SC_W'(1);
      end else if (32'(outliers_ff) > OUTLIER_SLOTS) begin
         z_lim = SC_W'(OUTLIER_SLOTS);
      end else begin
         z_lim = SC_W'(outliers_ff);
      end
   end

   // captured item
   logic [6:0]         didx_ff;
   logic signed [15:0] val_ff;
   logic [ID_W-1:0]    id_ff;
   logic [8:0]         slot_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         didx_ff <= req_coord_index;
         val_ff  <= req_coord_value;
         id_ff   <= req_point_id;
         slot_ff <= req_read_slot;
      end
   end

   // cluster counter, shared by accumulate and minimum passes
   logic [CK_W-1:0] cnt_ff, cnt_in;
   logic            cnt_last;

   assign cnt_last = (CK_W'(cnt_ff + 1'b1) == k_lim);

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.acc_step || cmd.min_step) begin
         cnt_in = cnt_last ? '0 : CK_W'(cnt_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // centroid store
   logic              cent_wr_en;
   logic [CA_W-1:0]   cent_wr_addr, cent_rd_addr;
   logic [COORD_W-1:0] cent_rd;

   assign cent_wr_en = cmd.cent_wr && (32'(req_centroid_index) < MAX_CLUSTERS)
                       && (32'(req_coord_index) < MAX_DIMS);
   assign cent_wr_addr = CA_W'(32'(req_centroid_index) * MAX_DIMS + 32'(req_coord_index));
   assign cent_rd_addr = CA_W'(32'(cnt_ff[CI_W-1:0]) * MAX_DIMS + 32'(didx_ff));

   ncot_ram #(.WIDTH(COORD_W), .DEPTH(CA_DEPTH)) u_cent_ram (
      .clock   (clock),
      .wr_en   (cent_wr_en),
      .wr_addr (cent_wr_addr),
      .wr_data (req_coord_value),
      .rd_en   (cmd.acc_step),
      .rd_addr (cent_rd_addr),
      .rd_data (cent_rd)
   );

   // accumulate pipeline: read, square, add
   logic              s1_v_ff, s2_v_ff;
   logic [CI_W-1:0]   s1_idx_ff, s2_idx_ff;
   logic [31:0]       prod_ff;
   logic signed [16:0] diff;
   logic [15:0]       mag;

   assign diff = {cent_rd[15], cent_rd} - {val_ff[15], val_ff};
   assign mag  = diff[16] ? 16'(~diff + 17'd1) : diff[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= cmd.acc_step;
         s2_v_ff <= s1_v_ff;
      end
      s1_idx_ff <= cnt_ff[CI_W-1:0];
      s2_idx_ff <= s1_idx_ff;
      prod_ff   <= mag * mag;
   end

   // per-cluster accumulators, one read address
   logic [DIST_W-1:0] sums_ff [MAX_CLUSTERS];
   logic [CI_W-1:0]   sum_idx;
   logic [DIST_W-1:0] sum_rd;
   logic [DIST_W:0]   sum_wide;
   logic [DIST_W-1:0] sum_sat;

   assign sum_idx  = s2_v_ff ? s2_idx_ff : cnt_ff[CI_W-1:0];
   assign sum_rd   = sums_ff[sum_idx];
   assign sum_wide = {1'b0, sum_rd} + (DIST_W + 1)'(prod_ff);
   assign sum_sat  = sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (reset || cmd.track) begin
         for (int i = 0; i < MAX_CLUSTERS; i++) begin
            sums_ff[i] <= '0;
         end
      end else if (s2_v_ff) begin
         sums_ff[s2_idx_ff] <= sum_sat;
      end
   end

   // nearest cluster, lowest index on ties
   logic [CI_W-1:0]   best_ff;
   logic [DIST_W-1:0] bestd_ff;

   always_ff @(posedge clock) begin
      if (cmd.min_step && ((cnt_ff == '0) || (sum_rd < bestd_ff))) begin
         best_ff  <= cnt_ff[CI_W-1:0];
         bestd_ff <= sum_rd;
      end
   end

   // outlier table
   logic [SC_W-1:0]   count_ff;
   logic [SA_W-1:0]   smallest_ff;
   logic [DIST_W-1:0] smin_ff;
   logic              kept_ff;
   logic [SC_W-1:0]   scan_ff;
   logic              q_v_ff;
   logic [SA_W-1:0]   q_idx_ff;
   logic              full, reject, scan_last;
   logic              tbl_wr_en;
   logic [SA_W-1:0]   tbl_wr_addr, tbl_rd_addr;
   logic [TBL_W-1:0]  tbl_rd;
   logic [DIST_W-1:0] tbl_rd_dist;
   logic [ID_W-1:0]   tbl_rd_id;

   assign full        = (count_ff >= z_lim);
   assign reject      = (bestd_ff <= smin_ff);
   assign scan_last   = (SC_W'(scan_ff + 1'b1) == z_lim);
   assign tbl_wr_en   = cmd.track && (!full || !reject);
   assign tbl_wr_addr = full ? smallest_ff : count_ff[SA_W-1:0];
   assign tbl_rd_addr = cmd.slot_rd ? SA_W'(32'(req_read_slot)) : scan_ff[SA_W-1:0];
   assign tbl_rd_dist = tbl_rd[DIST_W-1:0];
   assign tbl_rd_id   = tbl_rd[TBL_W-1:DIST_W];

   ncot_ram #(.WIDTH(TBL_W), .DEPTH(OUTLIER_SLOTS)) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data ({id_ff, bestd_ff}),
      .rd_en   (cmd.scan_step || cmd.slot_rd),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd)
   );

   // insert, replace and rescan for the smallest entry
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         smallest_ff <= '0;
         scan_ff     <= '0;
         q_v_ff      <= 1'b0;
      end else begin
         q_v_ff <= cmd.scan_step;
         if (cmd.scan_step) begin
            scan_ff <= scan_last ? '0 : SC_W'(scan_ff + 1'b1);
         end
         if (cmd.tbl_clear) begin
            count_ff    <= '0;
            smallest_ff <= '0;
         end else if (cmd.track) begin
            if (!full) begin
               count_ff <= SC_W'(count_ff + 1'b1);
               if (count_ff == '0) begin
                  smallest_ff <= '0;
               end else if (smin_ff > bestd_ff) begin
                  smallest_ff <= count_ff[SA_W-1:0];
               end
            end
         end else if (q_v_ff && (tbl_rd_dist < smin_ff)) begin
            smallest_ff <= q_idx_ff;
         end
      end
   end

   // distance of the smallest entry and the kept flag
   always_ff @(posedge clock) begin
      q_idx_ff <= scan_ff[SA_W-1:0];
      if (cmd.track) begin
         kept_ff <= !full || !reject;
         if (full ? !reject : ((count_ff == '0) || (smin_ff > bestd_ff))) begin
            smin_ff <= bestd_ff;
         end
      end else if (q_v_ff && (tbl_rd_dist < smin_ff)) begin
         smin_ff <= tbl_rd_dist;
      end
   end

   // result word register
   logic slot_ok;
   logic rsp_free;

   assign slot_ok  = (32'(slot_ff) < OUTLIER_SLOTS) && (32'(slot_ff) < 32'(count_ff));
   assign rsp_free = !rsp_valid || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.rsp_point || cmd.rsp_read) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
      if (cmd.rsp_point) begin
         rsp_result_kind     <= RES_ASSIGN;
         rsp_cluster         <= 4'(best_ff);
         rsp_distance        <= bestd_ff;
         rsp_result_point    <= id_ff;
         rsp_kept_as_outlier <= kept_ff;
         rsp_slot_filled     <= 1'b0;
      end else if (cmd.rsp_read) begin
         rsp_result_kind     <= RES_SLOT;
         rsp_cluster         <= 4'd0;
         rsp_distance        <= slot_ok ? tbl_rd_dist : '0;
         rsp_result_point    <= slot_ok ? tbl_rd_id : '0;
         rsp_kept_as_outlier <= 1'b0;
         rsp_slot_filled     <= slot_ok;
      end
   end

   // status back to the controller
   always_comb begin
      sts.coord_ok  = (32'(req_coord_index) < 32'(dims_ff))
                      && (32'(req_coord_index) < MAX_DIMS);
      sts.cnt_last  = cnt_last;
      sts.acc_busy  = s1_v_ff || s2_v_ff;
      sts.scan_last = scan_last;
      sts.scan_busy = q_v_ff;
      sts.need_scan = full && !reject;
      sts.rsp_free  = rsp_free;
   end

endmodule
`default_nettype wire

// ===== sv/ncot_ctrl.sv =====
`default_nettype none
module ncot_ctrl import ncot_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_kind,
   input  wire logic       req_last_coord,
   input  wire sts_type    sts,
   output cmd_type         cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ACC    = 4'd1;
   localparam logic [3:0] S_ADRAIN = 4'd2;
   localparam logic [3:0] S_MIN    = 4'd3;
   localparam logic [3:0] S_TRACK  = 4'd4;
   localparam logic [3:0] S_SCAN   = 4'd5;
   localparam logic [3:0] S_SDRAIN = 4'd6;
   localparam logic [3:0] S_RESP   = 4'd7;
   localparam logic [3:0] S_READ   = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       last_ff;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            last_ff <= req_last_coord;
         end
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               unique case (req_kind)
                  KIND_LOAD:  cmd.cent_wr = 1'b1;
                  KIND_CLEAR: cmd.tbl_clear = 1'b1;
                  KIND_POINT: begin
                     if (sts.coord_ok) begin
                        state_in = S_ACC;
                     end else if (req_last_coord) begin
                        state_in = S_MIN;
                     end
                  end
                  KIND_READ: begin
                     cmd.slot_rd = 1'b1;
                     state_in    = S_READ;
                  end
               endcase
            end
         end
         S_ACC: begin
            cmd.acc_step = 1'b1;
            if (sts.cnt_last) begin
               state_in = S_ADRAIN;
            end
         end
         S_ADRAIN: begin
            if (!sts.acc_busy) begin
               state_in = last_ff ? S_MIN : S_IDLE;
            end
         end
         S_MIN: begin
            cmd.min_step = 1'b1;
            if (sts.cnt_last) begin
               state_in = S_TRACK;
            end
         end
         S_TRACK: begin
            cmd.track = 1'b1;
            state_in  = sts.need_scan ? S_SCAN : S_RESP;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = S_SDRAIN;
            end
         end
         S_SDRAIN: begin
            if (!sts.scan_busy) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.rsp_point = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_READ: begin
            if (sts.rsp_free) begin
               cmd.rsp_read = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/nearest_centroid_outlier_tracker.sv =====
// Nearest-centroid assigner with a table of farthest points.
// Request channel (req_valid/req_stall): one word per item. Kind 0 loads a
// centroid coordinate, kind 1 streams a point coordinate, kind 2 empties the
// outlier table, kind 3 reads one slot back. Result channel (rsp_valid/
// rsp_stall) carries one word per final point coordinate and per slot read.
// Register port (csr_valid/csr_ready, always ready) sets clusters, dims and
// outlier slots in use; write it only while the block is idle.
// Steps, with k clusters in use and z slots in use:
//   load or clear: done when accepted; slot read: table RAM, result register.
//   point coordinate in range: the accepting cycle, one centroid RAM read and
//   one shared multiply-add per cluster, then the pipeline drains.
//   last coordinate adds a minimum search over k clusters, one table update and,
//   when a table entry is replaced, a rescan of the z slots over the
//   single read port of the table RAM, then the result register.
// A finished result sits in the output register; the next item is taken
// while it waits. A stalled receiver holds the word and blocks only the
// next item that has a result to deliver.
// Reset clears the accumulators, the outlier count and the registers to
// 16, 90 and 500. The memories are not cleared.
`default_nettype none
module nearest_centroid_outlier_tracker import ncot_pkg::*; #(
   parameter int MAX_CLUSTERS  = 16,
   parameter int MAX_DIMS      = 128,
   parameter int OUTLIER_SLOTS = 512
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_kind,
   input  wire logic [3:0]          req_centroid_index,
   input  wire logic [6:0]          req_coord_index,
   input  wire logic signed [15:0]  req_coord_value,
   input  wire logic [ID_W-1:0]     req_point_id,
   input  wire logic                req_last_coord,
   input  wire logic [8:0]          req_read_slot,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_result_kind,
   output logic [3:0]               rsp_cluster,
   output logic [DIST_W-1:0]        rsp_distance,
   output logic [ID_W-1:0]          rsp_result_point,
   output logic                     rsp_kept_as_outlier,
   output logic                     rsp_slot_filled,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [1:0]          csr_index,
   input  wire logic [CSR_W-1:0]    csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   ncot_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_last_coord (req_last_coord),
      .sts            (sts),
      .cmd            (cmd)
   );

   ncot_datapath #(
      .MAX_CLUSTERS  (MAX_CLUSTERS),
      .MAX_DIMS      (MAX_DIMS),
      .OUTLIER_SLOTS (OUTLIER_SLOTS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_centroid_index  (req_centroid_index),
      .req_coord_index     (req_coord_index),
      .req_coord_value     (req_coord_value),
      .req_point_id        (req_point_id),
      .req_read_slot       (req_read_slot),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_cluster         (rsp_cluster),
      .rsp_distance        (rsp_distance),
      .rsp_result_point    (rsp_result_point),
      .rsp_kept_as_outlier (rsp_kept_as_outlier),
      .rsp_slot_filled     (rsp_slot_filled)
   );

endmodule
`default_nettype wire
